### sv/kat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kat_pkg
// shared types, constants and register indexes of the key autorepeat tracker
// ----------------------------------------------------------------------------
package kat_pkg;

    localparam int KAT_KEY_COUNT = 32;
    localparam int KAT_KEY_W     = 32;
    localparam int KAT_TICK_W    = 32;
    localparam int KAT_DELAY_W   = 16;
    localparam int KAT_CFG_W     = 32;
    localparam int KAT_IDX_W     = 2;

    localparam logic [KAT_KEY_W-1:0]   KAT_MASK_RST  = 32'hFFFF_FFFF;
    localparam logic [KAT_DELAY_W-1:0] KAT_FIRST_RST = 16'd50;
    localparam logic [KAT_DELAY_W-1:0] KAT_IVL_RST   = 16'd10;

    localparam logic [KAT_IDX_W-1:0] KAT_REG_KEY_MASK    = 2'd0;
    localparam logic [KAT_IDX_W-1:0] KAT_REG_FIRST_DELAY = 2'd1;
    localparam logic [KAT_IDX_W-1:0] KAT_REG_REPEAT_IVL  = 2'd2;

    typedef struct packed {
        logic [KAT_KEY_W-1:0]  raw_keys;
        logic [KAT_TICK_W-1:0] now_ticks;
        logic                  start_ignore;
    } t_kat_in;

    typedef struct packed {
        logic [KAT_KEY_W-1:0] held_keys;
        logic [KAT_KEY_W-1:0] repeat_keys;
        logic                 ignoring;
    } t_kat_out;

    typedef enum logic [1:0] {
        KAT_OP_ADD_FIRST = 2'd0,
        KAT_OP_ADD_IVL   = 2'd1,
        KAT_OP_SUB_IVL   = 2'd2
    } t_kat_op;

    typedef struct packed {
        logic [KAT_TICK_W-1:0] sum;
        logic                  lt;
    } t_kat_alu_res;

endpackage

### sv/kat_dl_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kat_dl_mem
// deadline store, one write and one registered read port
// ----------------------------------------------------------------------------
module kat_dl_mem
    import kat_pkg::*;
#(
    parameter int DEPTH = KAT_KEY_COUNT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [KAT_TICK_W-1:0] i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic [KAT_TICK_W-1:0] o_rdata
);

    logic [KAT_TICK_W-1:0] r_mem [DEPTH];
    logic [KAT_TICK_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/kat_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kat_alu
// shared deadline adder and deadline-versus-now compare
// ----------------------------------------------------------------------------
module kat_alu
    import kat_pkg::*;
(
    input  t_kat_op                i_op,
    input  logic [KAT_TICK_W-1:0]  i_now,
    input  logic [KAT_TICK_W-1:0]  i_deadline,
    input  logic [KAT_DELAY_W-1:0] i_first_delay,
    input  logic [KAT_DELAY_W-1:0] i_repeat_ivl,
    output t_kat_alu_res           o_res
);

    logic [KAT_TICK_W-1:0] opnd;
    logic                  cin;

    always_comb begin
        opnd = KAT_TICK_W'(i_repeat_ivl);
        cin  = 1'b0;
        unique case (i_op)
            KAT_OP_ADD_FIRST: opnd = KAT_TICK_W'(i_first_delay);
            KAT_OP_ADD_IVL:   opnd = KAT_TICK_W'(i_repeat_ivl);
            KAT_OP_SUB_IVL: begin
                opnd = ~KAT_TICK_W'(i_repeat_ivl);
                cin  = 1'b1;
            end
            default: opnd = KAT_TICK_W'(i_repeat_ivl);
        endcase
    end

    assign o_res.sum = i_now + opnd + KAT_TICK_W'(cin);
    assign o_res.lt  = (i_deadline < i_now);

endmodule

### sv/key_autorepeat_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_autorepeat_tracker_core
// typematic autorepeat tracker for up to 32 keys
// ----------------------------------------------------------------------------
// For each accepted poll the sequencer walks the key slots one per cycle
// through a single deadline adder/comparator, with the deadline store read
// one slot ahead of the slot being updated, and then loads the result. The
// input is stalled for the whole walk and until the result is loaded; the
// next poll can be accepted in the cycle after that.
// A finished result sits in the output register while the next poll is
// accepted, and a result still held there by an output stall delays the load
// of the following one. No clearing pass is needed after reset.
module key_autorepeat_tracker_core
    import kat_pkg::*;
#(
    parameter int KEY_COUNT = KAT_KEY_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_kat_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_kat_out             o_out_data,
    input  logic                 i_cfg_we,
    input  logic [KAT_IDX_W-1:0] i_cfg_idx,
    input  logic [KAT_CFG_W-1:0] i_cfg_data
);

    localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int CW = $clog2(KEY_COUNT + 1);
    localparam logic [CW-1:0] LAST = CW'(KEY_COUNT);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [KAT_KEY_W-1:0]   r_key_mask;
    logic [KAT_DELAY_W-1:0] r_first_delay;
    logic [KAT_DELAY_W-1:0] r_repeat_ivl;
    logic [CW-1:0]          r_cnt;
    logic [AW-1:0]          r_slot;
    logic                   r_proc;
    logic [KEY_COUNT-1:0]   r_held;
    logic [KAT_TICK_W-1:0]  r_now;
    logic                   r_flag;
    logic [KEY_COUNT-1:0]   r_pb, n_pb;
    logic [KEY_COUNT-1:0]   r_rep, n_rep;
    logic                   r_out_valid;
    t_kat_out               r_out;

    logic                  in_acc;
    logic                  out_load;
    logic                  mem_we;
    logic [KAT_TICK_W-1:0] rdata;
    t_kat_op               op;
    t_kat_alu_res          alu_res;
    logic [KAT_KEY_W-1:0]  masked;
    logic [KAT_KEY_W-1:0]  held_ext;
    logic [KAT_KEY_W-1:0]  rep_ext;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign masked     = i_in_data.raw_keys & r_key_mask;

    kat_dl_mem #(
        .DEPTH (KEY_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_slot),
        .i_wdata (alu_res.sum),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (rdata)
    );

    kat_alu u_alu (
        .i_op          (op),
        .i_now         (r_now),
        .i_deadline    (rdata),
        .i_first_delay (r_first_delay),
        .i_repeat_ivl  (r_repeat_ivl),
        .o_res         (alu_res)
    );

    // per-slot update
    always_comb begin
        n_pb   = r_pb;
        n_rep  = r_rep;
        mem_we = 1'b0;
        op     = KAT_OP_SUB_IVL;
        if ((r_state == S_RUN) && r_proc) begin
            mem_we = 1'b1;
            if (r_held[r_slot]) begin
                if (r_pb[r_slot]) begin
                    if (alu_res.lt) begin
                        n_rep[r_slot] = 1'b1;
                        op            = KAT_OP_ADD_IVL;
                    end else begin
                        n_rep[r_slot] = 1'b0;
                        mem_we        = 1'b0;
                    end
                end else begin
                    n_pb[r_slot]  = 1'b1;
                    n_rep[r_slot] = 1'b1;
                    op            = KAT_OP_ADD_FIRST;
                end
            end else begin
                n_pb[r_slot]  = 1'b0;
                n_rep[r_slot] = 1'b0;
                op            = KAT_OP_SUB_IVL;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_RUN;
            S_RUN:   if (r_cnt == LAST) n_state = S_FIN;
            S_FIN:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        held_ext = '0;
        rep_ext  = '0;
        held_ext[KEY_COUNT-1:0] = r_held;
        rep_ext[KEY_COUNT-1:0]  = r_rep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_key_mask    <= KAT_MASK_RST;
            r_first_delay <= KAT_FIRST_RST;
            r_repeat_ivl  <= KAT_IVL_RST;
            r_cnt         <= '0;
            r_proc        <= 1'b0;
            r_flag        <= 1'b0;
            r_pb          <= '0;
            r_rep         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pb    <= n_pb;
            r_rep   <= n_rep;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    KAT_REG_KEY_MASK:    r_key_mask    <= i_cfg_data;
                    KAT_REG_FIRST_DELAY: r_first_delay <= i_cfg_data[KAT_DELAY_W-1:0];
                    KAT_REG_REPEAT_IVL:  r_repeat_ivl  <= i_cfg_data[KAT_DELAY_W-1:0];
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_cnt  <= '0;
                r_proc <= 1'b0;
                r_flag <= r_flag | i_in_data.start_ignore;
            end else if (r_state == S_RUN) begin
                if (r_cnt != LAST) begin
                    r_cnt  <= r_cnt + CW'(1);
                    r_proc <= 1'b1;
                end else begin
                    r_proc <= 1'b0;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_flag      <= r_flag && (r_held != '0);
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_held <= masked[KEY_COUNT-1:0];
            r_now  <= i_in_data.now_ticks;
        end
        if (r_state == S_RUN) begin
            r_slot <= r_cnt[AW-1:0];
        end
        if (out_load) begin
            r_out.held_keys   <= r_flag ? '0 : held_ext;
            r_out.repeat_keys <= r_flag ? '0 : rep_ext;
            r_out.ignoring    <= r_flag && (r_held != '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LAST)
        else $error("slot counter out of range");

    a_acc_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_RUN))
        else $error("accepted poll did not start the slot walk");

    a_fin_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && !r_out_valid |=> r_out_valid)
        else $error("finished poll not loaded into output register");

    a_rep_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.repeat_keys & ~o_out_data.held_keys) == '0))
        else $error("repeat reported for a key that is not held");
`endif

endmodule
